// ===== rtl/core/sobel_gradient_magnitude_top_macros.svh =====
// Assertion macros used by the checker in sgm_checker.sv.
`ifndef SOBEL_GRADIENT_MAGNITUDE_TOP_MACROS_SVH
`define SOBEL_GRADIENT_MAGNITUDE_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define SGM_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define SGM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/sgm_pkg.sv =====
package sgm_pkg;

   localparam int PIXEL_W    = 8;
   localparam int IMG_W_W    = 12;
   localparam int MAG_W      = 8;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int MIN_WIDTH  = 3;

   localparam logic [IMG_W_W-1:0] IMG_W_RESET = 12'd640;
   localparam logic [MAG_W-1:0]   MAG_SAT     = 8'd255;

   // register index, taken from paddr[2]
   localparam logic REG_IMAGE_WIDTH = 1'b0;

   // gradient and sum widths
   localparam int GRAD_W = 11;   // [-1020, 1020]
   localparam int SUM_W  = 21;   // gx^2 + gy^2 <= 2080800
   localparam int ROOT_W = 16;

   localparam int SQRT_STEPS = 8;

   typedef logic [2:0] tap_sel_type;
   typedef logic [2:0] root_idx_type;

   // history taps read from the RAM, in read order
   localparam tap_sel_type TAP_A0 = 3'd0;   // 2W+2
   localparam tap_sel_type TAP_A1 = 3'd1;   // 2W+1
   localparam tap_sel_type TAP_A2 = 3'd2;   // 2W
   localparam tap_sel_type TAP_B0 = 3'd3;   // W+2
   localparam tap_sel_type TAP_B2 = 3'd4;   // W

   typedef struct packed {
      logic         accept;
      logic         rd_en;
      tap_sel_type  rd_sel;
      logic         grad_en;
      logic         sqr_en;
      logic         sum_en;
      logic         root_en;
      root_idx_type root_idx;
      logic         out_load;
   } cmd_type;

   typedef struct packed {
      logic result_due;
      logic out_free;
   } status_type;

endpackage

// ===== rtl/core/sobel_gradient_magnitude_top.sv =====
// Channel   Direction  Handshake            Payload
// request   in         req_valid/req_stall  req_pixel[7:0], req_end_of_frame
// result    out        rsp_valid/rsp_stall  rsp_magnitude[7:0], rsp_last_result
// config    in         APB psel/penable     paddr[2:0], pwdata[31:0] -> prdata
//
// A request that makes no result is taken in the idle state; the next one can follow directly.
// A request that makes a result holds off the next: five reads on the single
//   read port of the pixel history RAM, a drain state, then gradient, square, sum,
//   an 8-step square root, and the output register load, once that register is free.
// Reset is synchronous; the history RAM is not cleared, since the frame position
//   counter keeps every window inside the current frame.
// req_stall is high while a request is in flight; a finished result waits in the
//   output register while rsp_stall is high, and the next request is taken meanwhile.
module sobel_gradient_magnitude_top #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [sgm_pkg::PIXEL_W-1:0]         req_pixel,
   input  logic                                req_end_of_frame,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [sgm_pkg::MAG_W-1:0]           rsp_magnitude,
   output logic                                rsp_last_result,
   // configuration port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [sgm_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [sgm_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [sgm_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready
);

   import sgm_pkg::*;

   logic [IMG_W_W-1:0] image_width_ff, image_width_in;
   logic               csr_wr;
   cmd_type            cmd;
   status_type         st;

   // Config register: one word, image width in bits 11:0.
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && (paddr[2] == REG_IMAGE_WIDTH);

   assign image_width_in = csr_wr ? pwdata[IMG_W_W-1:0] : image_width_ff;
   assign prdata = (paddr[2] == REG_IMAGE_WIDTH) ? CSR_DATA_W'(image_width_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff <= IMG_W_RESET;
      end else begin
         image_width_ff <= image_width_in;
      end
   end

   // Sequencer: accept, tap reads, arithmetic steps, output load.
   sgm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .st        (st),
      .cmd       (cmd)
   );

   // History RAM, window taps, gradient math, root unit, output register.
   sgm_dp #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .image_width      (image_width_ff),
      .req_pixel        (req_pixel),
      .req_end_of_frame (req_end_of_frame),
      .rsp_stall        (rsp_stall),
      .cmd              (cmd),
      .st               (st),
      .rsp_valid        (rsp_valid),
      .rsp_magnitude    (rsp_magnitude),
      .rsp_last_result  (rsp_last_result)
   );

endmodule

// ===== rtl/core/sgm_ram.sv =====
module sgm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4099
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/core/sgm_ctrl.sv =====
module sgm_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  sgm_pkg::status_type st,
   output sgm_pkg::cmd_type    cmd
);

   import sgm_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_READ  = 3'd1;
   localparam logic [2:0] ST_DRAIN = 3'd2;
   localparam logic [2:0] ST_GRAD  = 3'd3;
   localparam logic [2:0] ST_SQR   = 3'd4;
   localparam logic [2:0] ST_SUM   = 3'd5;
   localparam logic [2:0] ST_ROOT  = 3'd6;
   localparam logic [2:0] ST_OUT   = 3'd7;

   logic [2:0] state_ff, state_in;
   logic [2:0] cnt_ff, cnt_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      req_stall = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            cmd.accept = req_valid;
            if (req_valid && st.result_due) begin
               state_in = ST_READ;
               cnt_in   = TAP_A0;
            end
         end
         ST_READ: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = cnt_ff;
            if (cnt_ff == TAP_B2) begin
               state_in = ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_GRAD;
         end
         ST_GRAD: begin
            cmd.grad_en = 1'b1;
            state_in    = ST_SQR;
         end
         ST_SQR: begin
            cmd.sqr_en = 1'b1;
            state_in   = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum_en = 1'b1;
            state_in   = ST_ROOT;
            cnt_in     = 3'(SQRT_STEPS - 1);
         end
         ST_ROOT: begin
            cmd.root_en  = 1'b1;
            cmd.root_idx = cnt_ff;
            if (cnt_ff == 3'd0) begin
               state_in = ST_OUT;
            end else begin
               cnt_in = cnt_ff - 3'd1;
            end
         end
         ST_OUT: begin
            if (st.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ===== rtl/core/sgm_dp.sv =====
module sgm_dp #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [sgm_pkg::IMG_W_W-1:0]   image_width,
   input  logic [sgm_pkg::PIXEL_W-1:0]   req_pixel,
   input  logic                          req_end_of_frame,
   input  logic                          rsp_stall,
   input  sgm_pkg::cmd_type              cmd,
   output sgm_pkg::status_type           st,
   output logic                          rsp_valid,
   output logic [sgm_pkg::MAG_W-1:0]     rsp_magnitude,
   output logic                          rsp_last_result
);

   import sgm_pkg::*;

   localparam int DEPTH     = 2 * MAX_WIDTH + 3;
   localparam int AW        = $clog2(DEPTH);
   localparam int WW        = $clog2(MAX_WIDTH + 1);
   localparam int POS_LIMIT = DEPTH - 1;

   logic [WW-1:0] w_eff;
   logic [AW-1:0] span2;
   logic [AW-1:0] tap_k;
   logic [AW-1:0] wr_ff, wr_next;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] pos_ff, pos_in;
   logic [PIXEL_W-1:0] ram_q;

   logic          rd_pend_ff;
   tap_sel_type   rd_sel_ff;

   logic [PIXEL_W-1:0] a0_ff, a1_ff, a2_ff, b0_ff, b2_ff, c0_ff, c1_ff, c2_ff;
   logic               eof_ff;

   logic [9:0]               sxa, sxc, sya, syc;
   logic signed [GRAD_W-1:0] gx_ff, gy_ff;
   logic signed [2*GRAD_W-1:0] px, py;
   logic [SUM_W-1:0]         sqx_ff, sqy_ff, sum;
   logic                     sat_ff;
   logic [ROOT_W-1:0]        rem_ff, root_ff, bitv;
   logic [ROOT_W:0]          trial;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [MAG_W-1:0]   mag_ff;
   logic               last_ff;

   // effective row width, clamped
   always_comb begin
      if (image_width < IMG_W_W'(MIN_WIDTH)) begin
         w_eff = WW'(MIN_WIDTH);
      end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(image_width);
      end
   end

   assign span2 = AW'({w_eff, 1'b0}) + AW'(2);

   always_comb begin
      case (cmd.rd_sel)
         TAP_A0:  tap_k = span2;
         TAP_A1:  tap_k = span2 - AW'(1);
         TAP_A2:  tap_k = span2 - AW'(2);
         TAP_B0:  tap_k = AW'(w_eff) + AW'(2);
         TAP_B2:  tap_k = AW'(w_eff);
         default: tap_k = span2;
      endcase
   end

   // circular history: wrap the offset back into range
   assign rd_addr = (wr_ff >= tap_k) ? (wr_ff - tap_k) : (wr_ff + AW'(DEPTH) - tap_k);
   assign wr_next = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + AW'(1);

   sgm_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (DEPTH)
   ) u_hist (
      .clock   (clock),
      .wr_en   (cmd.accept),
      .wr_addr (wr_next),
      .wr_data (req_pixel),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   always_comb begin
      pos_in = pos_ff;
      if (cmd.accept) begin
         if (req_end_of_frame) begin
            pos_in = '0;
         end else if (pos_ff < AW'(POS_LIMIT)) begin
            pos_in = pos_ff + AW'(1);
         end
      end
   end

   assign st.result_due = (pos_ff >= span2);
   assign st.out_free   = !rsp_valid_ff || !rsp_stall;

   // arithmetic
   assign sxa = 10'(a0_ff) + 10'({a1_ff, 1'b0}) + 10'(a2_ff);
   assign sxc = 10'(c0_ff) + 10'({c1_ff, 1'b0}) + 10'(c2_ff);
   assign sya = 10'(a0_ff) + 10'({b0_ff, 1'b0}) + 10'(c0_ff);
   assign syc = 10'(a2_ff) + 10'({b2_ff, 1'b0}) + 10'(c2_ff);

   assign px    = gx_ff * gx_ff;
   assign py    = gy_ff * gy_ff;
   assign sum   = sqx_ff + sqy_ff;
   assign bitv  = ROOT_W'(1) << {cmd.root_idx, 1'b0};
   assign trial = {1'b0, root_ff} + {1'b0, bitv};

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff        <= '0;
         pos_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.accept) begin
            wr_ff <= wr_next;
         end
         pos_ff       <= pos_in;
         rd_pend_ff   <= cmd.rd_en;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_sel_ff <= cmd.rd_sel;
      if (cmd.accept) begin
         c2_ff  <= req_pixel;
         c1_ff  <= c2_ff;
         c0_ff  <= c1_ff;
         eof_ff <= req_end_of_frame;
      end
      if (rd_pend_ff) begin
         case (rd_sel_ff)
            TAP_A0:  a0_ff <= ram_q;
            TAP_A1:  a1_ff <= ram_q;
            TAP_A2:  a2_ff <= ram_q;
            TAP_B0:  b0_ff <= ram_q;
            TAP_B2:  b2_ff <= ram_q;
            default: ;
         endcase
      end
      if (cmd.grad_en) begin
         gx_ff <= $signed({1'b0, sxa}) - $signed({1'b0, sxc});
         gy_ff <= $signed({1'b0, sya}) - $signed({1'b0, syc});
      end
      if (cmd.sqr_en) begin
         sqx_ff <= px[SUM_W-1:0];
         sqy_ff <= py[SUM_W-1:0];
      end
      if (cmd.sum_en) begin
         sat_ff  <= |sum[SUM_W-1:ROOT_W];
         rem_ff  <= sum[ROOT_W-1:0];
         root_ff <= '0;
      end
      if (cmd.root_en) begin
         if ({1'b0, rem_ff} >= trial) begin
            rem_ff  <= rem_ff - trial[ROOT_W-1:0];
            root_ff <= (root_ff >> 1) + bitv;
         end else begin
            root_ff <= root_ff >> 1;
         end
      end
      if (cmd.out_load) begin
         mag_ff  <= sat_ff ? MAG_SAT : root_ff[MAG_W-1:0];
         last_ff <= eof_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_magnitude   = mag_ff;
   assign rsp_last_result = last_ff;

endmodule

// ===== rtl/core/sgm_checker.sv =====
`include "sobel_gradient_magnitude_top_macros.svh"

module sgm_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic [sgm_pkg::PIXEL_W-1:0]    req_pixel,
   input logic                           req_end_of_frame,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [sgm_pkg::MAG_W-1:0]      rsp_magnitude,
   input logic                           rsp_last_result,
   input logic                           psel,
   input logic                           penable,
   input logic                           pwrite,
   input logic [sgm_pkg::CSR_ADDR_W-1:0] paddr,
   input logic [sgm_pkg::CSR_DATA_W-1:0] pwdata,
   input logic [sgm_pkg::CSR_DATA_W-1:0] prdata,
   input logic                           pready
);

   // a held result keeps its payload
   `SGM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_magnitude) && $stable(rsp_last_result), "result changed while stalled")

   // a new result only comes out of a busy stretch
   `SGM_ASSERT_NOW(a_rsp_after_busy, clock, reset, $rose(rsp_valid), $past(req_stall), "result appeared without work in flight")

   // a request never turns into a result on the next edge
   `SGM_ASSERT_NEXT(a_no_instant_rsp, clock, reset, req_valid && !req_stall, !$rose(rsp_valid), "result too early after request")

endmodule

bind sobel_gradient_magnitude_top sgm_checker u_sgm_checker (.*);

// ===== tb/sobel_magnitude_checker.sv =====
module sobel_magnitude_checker #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  logic [sgm_pkg::PIXEL_W-1:0]      req_pixel,
   input  logic                             req_end_of_frame,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  logic [sgm_pkg::MAG_W-1:0]        rsp_magnitude,
   input  logic                             rsp_last_result,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [sgm_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [sgm_pkg::CSR_DATA_W-1:0]   pwdata,
   input  logic [sgm_pkg::CSR_DATA_W-1:0]   prdata,
   input  logic                             pready,
   output int                               mismatches,
   output int                               mags_pending,
   output int                               mags_checked,
   output int                               frame_ends_checked
);
   import sgm_pkg::*;

   localparam int LINE_DEPTH = 2 * MAX_WIDTH + 3;
   localparam int POS_LIMIT  = 2 * MAX_WIDTH + 2;

   typedef struct packed {
      logic [MAG_W-1:0] magnitude;
      logic             last_result;
   } grad_result_t;

   logic [PIXEL_W-1:0] line_buf [LINE_DEPTH];
   int                 newest;
   int                 frame_pos;
   logic [IMG_W_W-1:0] width_reg;
   grad_result_t       mag_expected_q [$];

   function automatic int clamped_width(logic [IMG_W_W-1:0] w);
      if (w < MIN_WIDTH) return MIN_WIDTH;
      if (w > MAX_WIDTH) return MAX_WIDTH;
      return int'(w);
   endfunction

   // sample k steps older than the newest one
   function automatic int pixel_back(int k);
      return int'(line_buf[(newest + LINE_DEPTH - k) % LINE_DEPTH]);
   endfunction

   function automatic logic [MAG_W-1:0] floor_root(int s);
      logic [MAG_W-1:0] r;
      logic [MAG_W-1:0] t;
      int               b;
      r = '0;
      for (b = MAG_W - 1; b >= 0; b--) begin
         t = r | (MAG_W'(1) << b);
         if (int'(t) * int'(t) <= s) r = t;
      end
      return r;
   endfunction

   function automatic void advance_window(logic [PIXEL_W-1:0] px, logic eof);
      int           w;
      int           a0, a1, a2, b0, b2, c0, c1, c2;
      int           gx, gy, s;
      grad_result_t res;
      w = clamped_width(width_reg);
      newest = (newest + 1) % LINE_DEPTH;
      line_buf[newest] = px;
      if (frame_pos >= 2 * w + 2) begin
         a0 = pixel_back(2 * w + 2);
         a1 = pixel_back(2 * w + 1);
         a2 = pixel_back(2 * w);
         b0 = pixel_back(w + 2);
         b2 = pixel_back(w);
         c0 = pixel_back(2);
         c1 = pixel_back(1);
         c2 = pixel_back(0);
         gx = (a0 + 2 * a1 + a2) - (c0 + 2 * c1 + c2);
         gy = (a0 + 2 * b0 + c0) - (a2 + 2 * b2 + c2);
         s  = gx * gx + gy * gy;
         res.magnitude   = (s >= 65536) ? MAG_SAT : floor_root(s);
         res.last_result = eof;
         mag_expected_q.push_back(res);
      end
      if (eof) frame_pos = 0;
      else if (frame_pos < POS_LIMIT) frame_pos++;
   endfunction

   always @(posedge clock) begin
      grad_result_t want;
      if (reset) begin
         for (int i = 0; i < LINE_DEPTH; i++) line_buf[i] = '0;
         newest    = 0;
         frame_pos = 0;
         width_reg = IMG_W_RESET;
         mag_expected_q.delete();
      end else begin
         // pop before push: a result never leaves in the cycle its request enters
         if (rsp_valid && !rsp_stall) begin
            if (mag_expected_q.size() == 0) begin
               mismatches++;
               $error("unexpected result: magnitude %0d, last_result %0b",
                      rsp_magnitude, rsp_last_result);
            end else begin
               want = mag_expected_q.pop_front();
               mags_checked++;
               if (want.last_result) frame_ends_checked++;
               if (rsp_magnitude !== want.magnitude) begin
                  mismatches++;
                  $error("magnitude: expected %0d, got %0d", want.magnitude, rsp_magnitude);
               end
               if (rsp_last_result !== want.last_result) begin
                  mismatches++;
                  $error("last_result: expected %0b, got %0b",
                         want.last_result, rsp_last_result);
               end
            end
         end
         if (req_valid && !req_stall) advance_window(req_pixel, req_end_of_frame);
         if (psel && penable && pready && paddr[CSR_ADDR_W-1] == REG_IMAGE_WIDTH) begin
            if (pwrite) begin
               width_reg = pwdata[IMG_W_W-1:0];
            end else if (prdata !== CSR_DATA_W'(width_reg)) begin
               mismatches++;
               $error("image_width: expected %0d, got %0d", width_reg, prdata);
            end
         end
      end
      mags_pending <= mag_expected_q.size();
   end

endmodule

// ===== tb/tb.sv =====
module tb;
   import sgm_pkg::*;

   localparam int MAX_WIDTH       = 2048;
   localparam int RANDOM_REQUESTS = 700;
   // margin for the result path and for output stalls
   localparam int DRAIN_CYCLES    = 40;
   // window with no random request gaps and no output stalls
   localparam int QUIET_FROM      = 2000;
   localparam int QUIET_TO        = 7000;
   localparam int TIMEOUT_CYCLES  = 400000;

   localparam logic [CSR_ADDR_W-1:0] IMAGE_WIDTH_ADDR = {REG_IMAGE_WIDTH, 2'b00};

   typedef enum int {TEXTURE_NOISE, TEXTURE_BINARY, TEXTURE_SMOOTH} texture_t;

   logic                  clock            = 1'b0;
   logic                  reset            = 1'b1;
   logic                  req_valid        = 1'b0;
   logic                  req_stall;
   logic [PIXEL_W-1:0]    req_pixel        = '0;
   logic                  req_end_of_frame = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall        = 1'b0;
   logic [MAG_W-1:0]      rsp_magnitude;
   logic                  rsp_last_result;
   logic                  psel             = 1'b0;
   logic                  penable          = 1'b0;
   logic                  pwrite           = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr            = '0;
   logic [CSR_DATA_W-1:0] pwdata           = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int   cycle_count;
   int   requests_sent;
   int   frames_sent;
   int   widths_used;
   int   mismatches, mags_pending, mags_checked, frame_ends_checked;
   logic quiet;

   always #6 clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;
   assign quiet = (cycle_count >= QUIET_FROM) && (cycle_count < QUIET_TO);

   // Output side: random stalls at about 9 percent, none inside the quiet window.
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= !quiet && ($urandom_range(99) < 9);
   end

   sobel_gradient_magnitude_top #(
      .MAX_WIDTH(MAX_WIDTH)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pixel        (req_pixel),
      .req_end_of_frame (req_end_of_frame),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_magnitude    (rsp_magnitude),
      .rsp_last_result  (rsp_last_result),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   // Predicts every magnitude, checks results and CSR read-back.
   sobel_magnitude_checker #(
      .MAX_WIDTH(MAX_WIDTH)
   ) i_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_pixel          (req_pixel),
      .req_end_of_frame   (req_end_of_frame),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_magnitude      (rsp_magnitude),
      .rsp_last_result    (rsp_last_result),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready),
      .mismatches         (mismatches),
      .mags_pending       (mags_pending),
      .mags_checked       (mags_checked),
      .frame_ends_checked (frame_ends_checked)
   );

   // Next sample of a frame; smooth texture keeps gradients small so the
   // square root is exercised well below saturation.
   function automatic logic [PIXEL_W-1:0] next_pixel(texture_t tex, logic [PIXEL_W-1:0] prev);
      int v;
      case (tex)
         TEXTURE_BINARY: begin
            return ($urandom_range(1) == 0) ? '0 : '1;
         end
         TEXTURE_SMOOTH: begin
            v = int'(prev) + int'($urandom_range(6)) - 3;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            return PIXEL_W'(v);
         end
         default: begin
            return PIXEL_W'($urandom);
         end
      endcase
   endfunction

   // One pixel request. Valid is held until accepted; random gaps in front
   // of it, none in the quiet window.
   task automatic send_pixel(input logic [PIXEL_W-1:0] px, input logic eof);
      while (!quiet && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_pixel        <= px;
      req_end_of_frame <= eof;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      requests_sent++;
   endtask

   task automatic send_frame(input int len, input texture_t tex);
      logic [PIXEL_W-1:0] px;
      px = PIXEL_W'($urandom);
      for (int i = 0; i < len; i++) begin
         px = next_pixel(tex, px);
         send_pixel(px, i == len - 1);
      end
      frames_sent++;
   endtask

   // Hold the sender until every predicted result is out, then let the
   // pipeline settle (a no-result request may still be in flight).
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (mags_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // APB transfer to the image_width register: setup, then access.
   task automatic csr_access(input logic write, input logic [IMG_W_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write;
      paddr   <= IMAGE_WIDTH_ADDR;
      pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Wait for idle, write then read back; the checker compares the read data.
   task automatic set_width(input logic [IMG_W_W-1:0] value);
      wait_idle();
      csr_access(1'b1, value);
      csr_access(1'b0, value);
      widths_used++;
   endtask

   initial begin : stimulus
      int                 eff;
      int                 len;
      int                 base;
      int                 phase_end;
      int                 ph;
      logic [IMG_W_W-1:0] wval;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset value of image_width read back
      csr_access(1'b0, '0);

      // --- directed: width 0 clamps to 3, so results start at the 9th pixel
      set_width('0);
      // short frame: ends before any window is complete, no result
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd0,   1'b0);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd0,   1'b1);
      // bright top rows over dark bottom: saturated magnitude in every window
      for (int i = 0; i < 11; i++) send_pixel((i < 6) ? 8'd255 : 8'd0, i == 10);
      // flat frame: zero gradient, last result flagged
      for (int i = 0; i < 10; i++) send_pixel(8'd128, i == 9);
      frames_sent += 3;

      // --- random phases over a spread of widths, fixed small ones (some clamped) first
      base = requests_sent;
      ph   = 0;
      while (requests_sent - base < RANDOM_REQUESTS) begin
         case (ph)
            0:       wval = IMG_W_W'(3);
            1:       wval = IMG_W_W'(1);
            2:       wval = IMG_W_W'(2);
            3:       wval = IMG_W_W'(4);
            default: wval = ($urandom_range(7) == 0) ? IMG_W_W'($urandom_range(2))
                                                     : IMG_W_W'($urandom_range(48, 3));
         endcase
         set_width(wval);
         eff       = (wval < MIN_WIDTH) ? MIN_WIDTH : int'(wval);
         phase_end = requests_sent + 100;
         while (requests_sent < phase_end) begin
            // mostly frames long enough to give results, some cut short
            if ($urandom_range(3) == 0) len = $urandom_range(2 * eff + 1, 1);
            else len = 2 * eff + 2 + $urandom_range(30, 1);
            send_frame(len, texture_t'($urandom_range(2)));
            // occasional full drain of the result side mid-phase
            if ($urandom_range(5) == 0) wait_idle();
         end
         ph++;
      end

      // --- widest rows: 2048 read back, then 4095 which clamps to 2048;
      // the frame position reaches its saturation value here
      set_width(IMG_W_W'(MAX_WIDTH));
      set_width('1);
      send_frame(2 * MAX_WIDTH + 2 + 20, TEXTURE_NOISE);

      wait_idle();
      $display("Drove %0d pixel requests in %0d frames over %0d image width settings,",
               requests_sent, frames_sent, widths_used);
      $display("clamped widths included; %0d magnitudes compared, %0d closing a frame.",
               mags_checked, frame_ends_checked);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin
      repeat (TIMEOUT_CYCLES) @(posedge clock);
      $display("Timeout with %0d results outstanding", mags_pending);
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/sgm_pkg.sv
rtl/core/sgm_ram.sv
rtl/core/sgm_ctrl.sv
rtl/core/sgm_dp.sv
rtl/core/sobel_gradient_magnitude_top.sv
rtl/core/sgm_checker.sv
tb/sobel_magnitude_checker.sv
tb/tb.sv
